// ===== hdl/dpcm_pkg.sv =====
// Shared types, register indexes and the delta table of the DPCM audio frame decoder.
`default_nettype none

package dpcm_pkg;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEREO     = 2'd0,
        REG_COMPRESSED = 2'd1,
        REG_WIDE_PCM   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic stereo;
        logic compressed;
        logic wide_pcm;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
        logic              frame_last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       channel;
    } result_t;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    localparam logic signed [SAMPLE_W-1:0] STEP_TABLE [256] = '{
             16'sd0,      16'sd1,      16'sd2,      16'sd3,
             16'sd4,      16'sd5,      16'sd6,      16'sd7,
             16'sd8,      16'sd9,     16'sd10,     16'sd11,
            16'sd12,     16'sd13,     16'sd14,     16'sd15,
            16'sd16,     16'sd17,     16'sd18,     16'sd19,
            16'sd20,     16'sd21,     16'sd22,     16'sd23,
            16'sd24,     16'sd25,     16'sd26,     16'sd27,
            16'sd28,     16'sd29,     16'sd30,     16'sd31,
            16'sd32,     16'sd33,     16'sd34,     16'sd35,
            16'sd36,     16'sd37,     16'sd38,     16'sd39,
            16'sd40,     16'sd41,     16'sd42,     16'sd43,
            16'sd47,     16'sd51,     16'sd56,     16'sd61,
            16'sd66,     16'sd72,     16'sd79,     16'sd86,
            16'sd94,    16'sd102,    16'sd112,    16'sd122,
           16'sd133,    16'sd145,    16'sd158,    16'sd173,
           16'sd189,    16'sd206,    16'sd225,    16'sd245,
           16'sd267,    16'sd292,    16'sd318,    16'sd348,
           16'sd379,    16'sd414,    16'sd452,    16'sd493,
           16'sd538,    16'sd587,    16'sd640,    16'sd699,
           16'sd763,    16'sd832,    16'sd908,    16'sd991,
          16'sd1081,   16'sd1180,   16'sd1288,   16'sd1405,
          16'sd1534,   16'sd1673,   16'sd1826,   16'sd1993,
          16'sd2175,   16'sd2373,   16'sd2590,   16'sd2826,
          16'sd3084,   16'sd3365,   16'sd3672,   16'sd4008,
          16'sd4373,   16'sd4772,   16'sd5208,   16'sd5683,
          16'sd6202,   16'sd6767,   16'sd7385,   16'sd8059,
          16'sd8794,   16'sd9597,  16'sd10472,  16'sd11428,
         16'sd12471,  16'sd13609,  16'sd14851,  16'sd16206,
         16'sd17685,  16'sd19298,  16'sd21060,  16'sd22981,
         16'sd25078,  16'sd27367,  16'sd29864,  16'sd32589,
        -16'sd29973, -16'sd26728, -16'sd23186, -16'sd19322,
        -16'sd15105, -16'sd10503,  -16'sd5481,     -16'sd1,
              16'sd1,      16'sd1,   16'sd5481,  16'sd10503,
          16'sd15105,  16'sd19322,  16'sd23186,  16'sd26728,
          16'sd29973, -16'sd32589, -16'sd29864, -16'sd27367,
        -16'sd25078, -16'sd22981, -16'sd21060, -16'sd19298,
        -16'sd17685, -16'sd16206, -16'sd14851, -16'sd13609,
        -16'sd12471, -16'sd11428, -16'sd10472,  -16'sd9597,
         -16'sd8794,  -16'sd8059,  -16'sd7385,  -16'sd6767,
         -16'sd6202,  -16'sd5683,  -16'sd5208,  -16'sd4772,
         -16'sd4373,  -16'sd4008,  -16'sd3672,  -16'sd3365,
         -16'sd3084,  -16'sd2826,  -16'sd2590,  -16'sd2373,
         -16'sd2175,  -16'sd1993,  -16'sd1826,  -16'sd1673,
         -16'sd1534,  -16'sd1405,  -16'sd1288,  -16'sd1180,
         -16'sd1081,   -16'sd991,   -16'sd908,   -16'sd832,
          -16'sd763,   -16'sd699,   -16'sd640,   -16'sd587,
          -16'sd538,   -16'sd493,   -16'sd452,   -16'sd414,
          -16'sd379,   -16'sd348,   -16'sd318,   -16'sd292,
          -16'sd267,   -16'sd245,   -16'sd225,   -16'sd206,
          -16'sd189,   -16'sd173,   -16'sd158,   -16'sd145,
          -16'sd133,   -16'sd122,   -16'sd112,   -16'sd102,
           -16'sd94,    -16'sd86,    -16'sd79,    -16'sd72,
           -16'sd66,    -16'sd61,    -16'sd56,    -16'sd51,
           -16'sd47,    -16'sd43,    -16'sd42,    -16'sd41,
           -16'sd40,    -16'sd39,    -16'sd38,    -16'sd37,
           -16'sd36,    -16'sd35,    -16'sd34,    -16'sd33,
           -16'sd32,    -16'sd31,    -16'sd30,    -16'sd29,
           -16'sd28,    -16'sd27,    -16'sd26,    -16'sd25,
           -16'sd24,    -16'sd23,    -16'sd22,    -16'sd21,
           -16'sd20,    -16'sd19,    -16'sd18,    -16'sd17,
           -16'sd16,    -16'sd15,    -16'sd14,    -16'sd13,
           -16'sd12,    -16'sd11,    -16'sd10,     -16'sd9,
            -16'sd8,     -16'sd7,     -16'sd6,     -16'sd5,
            -16'sd4,     -16'sd3,     -16'sd2,     -16'sd1
    };

endpackage

`default_nettype wire

// ===== hdl/dpcm_cfg_regs.sv =====
// Configuration registers of the DPCM audio frame decoder.
`default_nettype none

module dpcm_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dpcm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [dpcm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output dpcm_pkg::cfg_t                         cfg
);
    import dpcm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_addr))
                REG_STEREO:     cfg_next.stereo     = cfg_wdata[0];
                REG_COMPRESSED: cfg_next.compressed = cfg_wdata[0];
                REG_WIDE_PCM:   cfg_next.wide_pcm   = cfg_wdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{stereo: 1'b0, compressed: 1'b0, wide_pcm: 1'b1};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/dpcm_decode_core.sv =====
// Input register, decoder state and single-pass sample decode.
`default_nettype none

module dpcm_decode_core (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire dpcm_pkg::cfg_t cfg,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire dpcm_pkg::in_item_t in_item,
    input  wire logic         res_space,
    output logic              res_push,
    output dpcm_pkg::result_t res
);
    import dpcm_pkg::*;

    logic                       in_vld_reg;
    in_item_t                   item_reg;
    logic [SAMPLE_W-1:0]        pred_reg [2];
    logic [SAMPLE_W-1:0]        pred_next [2];
    logic                       chan_reg;
    logic                       chan_next;
    logic [1:0]                 seen_reg;
    logic [1:0]                 seen_next;
    logic [BYTE_W-1:0]          held_reg;
    logic [BYTE_W-1:0]          held_next;
    logic                       phase_reg;
    logic                       phase_next;

    logic                       fire;
    logic [1:0]                 seen_cur;
    logic                       chan_cur;
    logic                       phase_cur;
    logic                       seed;
    logic [SAMPLE_W-1:0]        word;
    logic signed [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0]        sat;
    logic                       res_vld;

    assign fire     = in_vld_reg && res_space;
    assign in_ready = !in_vld_reg || res_space;

    assign seen_cur  = item_reg.frame_start ? 2'd0 : seen_reg;
    assign chan_cur  = item_reg.frame_start ? 1'b0 : chan_reg;
    assign phase_cur = item_reg.frame_start ? 1'b0 : phase_reg;
    assign seed      = seen_cur <= {1'b0, cfg.stereo};
    assign word      = {item_reg.data_byte, held_reg};

    assign sum = {pred_reg[chan_cur][SAMPLE_W-1], pred_reg[chan_cur]}
               + {STEP_TABLE[item_reg.data_byte][SAMPLE_W-1],
                  STEP_TABLE[item_reg.data_byte]};

    always_comb begin
        if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
            sat = sum[SAMPLE_W] ? SAT_MIN : SAT_MAX;
        end else begin
            sat = sum[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        pred_next[0] = pred_reg[0];
        pred_next[1] = pred_reg[1];
        chan_next    = chan_cur;
        seen_next    = seen_cur;
        held_next    = held_reg;
        phase_next   = phase_cur;
        res_vld      = 1'b0;
        res.sample   = '0;
        res.channel  = 1'b0;
        if (cfg.compressed) begin
            if (seed) begin
                if (!phase_cur) begin
                    held_next  = item_reg.data_byte;
                    phase_next = 1'b1;
                end else begin
                    phase_next            = 1'b0;
                    pred_next[seen_cur[0]] = word;
                    seen_next             = seen_cur + 2'd1;
                    res_vld               = 1'b1;
                    res.sample            = word;
                    res.channel           = seen_cur[0];
                end
            end else if (!(cfg.stereo && item_reg.frame_last && !chan_cur)) begin
                pred_next[chan_cur] = sat;
                chan_next           = chan_cur ^ cfg.stereo;
                res_vld             = 1'b1;
                res.sample          = sat;
                res.channel         = chan_cur;
            end
        end else if (!cfg.wide_pcm) begin
            res_vld    = 1'b1;
            res.sample = {~item_reg.data_byte[BYTE_W-1], item_reg.data_byte[BYTE_W-2:0],
                          {BYTE_W{1'b0}}};
        end else if (!phase_cur) begin
            held_next  = item_reg.data_byte;
            phase_next = 1'b1;
        end else begin
            phase_next = 1'b0;
            res_vld    = 1'b1;
            res.sample = word;
        end
    end

    assign res_push = fire && res_vld;

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            item_reg <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            pred_reg[0] <= '0;
            pred_reg[1] <= '0;
            chan_reg    <= 1'b0;
            seen_reg    <= 2'd0;
            held_reg    <= '0;
            phase_reg   <= 1'b0;
        end else begin
            if (in_ready) begin
                in_vld_reg <= in_valid;
            end
            if (fire) begin
                pred_reg[0] <= pred_next[0];
                pred_reg[1] <= pred_next[1];
                chan_reg    <= chan_next;
                seen_reg    <= seen_next;
                held_reg    <= held_next;
                phase_reg   <= phase_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dpcm_out_skid.sv =====
// Two-entry result buffer that decouples the decoder from the result channel.
`default_nettype none

module dpcm_out_skid (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire dpcm_pkg::result_t push_data,
    output logic               space,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dpcm_pkg::result_t  out_data
);
    import dpcm_pkg::*;

    result_t     buf_mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        pop;

    assign space     = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_data  = buf_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/dpcm_audio_frame_decoder.sv =====
// Path: an accepted byte is held in the input register, decoded, and its sample is written into the result buffer.
// Throughput: one byte per cycle while the result buffer has space; the predictor add and saturate are combinational.
// Backpressure is absorbed by a two-entry result buffer; s_tready depends on registers only.
// Reset: synchronous, active low; clears predictors, frame phase and buffers,
// and sets stereo=0, compressed=0, wide_pcm=1.
`default_nettype none

module dpcm_audio_frame_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dpcm_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [dpcm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // [7:0] data_byte
    input  wire logic                              s_tuser,   // [0] frame_start
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [15:0]                            m_tdata,   // [15:0] sample
    output logic                                   m_tuser    // [0] channel
);
    import dpcm_pkg::*;

    cfg_t     cfg;
    in_item_t in_item;
    result_t  res;
    result_t  out_res;
    logic     res_push;
    logic     res_space;

    assign in_item.data_byte   = s_tdata;
    assign in_item.frame_start = s_tuser;
    assign in_item.frame_last  = s_tlast;

    dpcm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dpcm_decode_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_space (res_space),
        .res_push  (res_push),
        .res       (res)
    );

    dpcm_out_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .space     (res_space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = out_res.sample;
    assign m_tuser = out_res.channel;

endmodule

`default_nettype wire
